### rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define SLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SLM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/slm_pkg.sv
package slm_pkg;

  // Sample and average formats
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 8;
  localparam int AVG_BITS      = SAMPLE_BITS + FRACTION_BITS;

  // Register field widths
  localparam int THR_BITS    = 15;
  localparam int WEIGHT_BITS = 17;
  localparam int WEIGHT_FRAC = 16;
  localparam int COUNT_BITS  = 16;
  localparam int CHANGE_BITS = 32;
  localparam int ZONE_BITS   = 3;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = WEIGHT_BITS;

  // 0.25 in Q1.16, and 1.0
  localparam logic [WEIGHT_BITS-1:0] DEFAULT_WEIGHT = WEIGHT_BITS'(16384);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE     = WEIGHT_BITS'(65536);

  typedef enum logic [ZONE_BITS-1:0] {
    ZONE_NORMAL   = 3'd0,
    ZONE_ALARM    = 3'd1,
    ZONE_SHORT    = 3'd2,
    ZONE_OPEN     = 3'd3,
    ZONE_UNSTABLE = 3'd4,
    ZONE_FAULT    = 3'd5
  } zone_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SHORT_LIMIT = 3'd0,
    REG_NORMAL_LOW  = 3'd1,
    REG_NORMAL_HIGH = 3'd2,
    REG_ALARM_LOW   = 3'd3,
    REG_ALARM_HIGH  = 3'd4,
    REG_OPEN_LOW    = 3'd5,
    REG_WEIGHT      = 3'd6,
    REG_SETTLE      = 3'd7
  } cfg_reg_t;

  // Band thresholds and settle count, as seen by the zone tracker
  typedef struct packed {
    logic [THR_BITS-1:0]   short_limit;
    logic [THR_BITS-1:0]   normal_low;
    logic [THR_BITS-1:0]   normal_high;
    logic [THR_BITS-1:0]   alarm_low;
    logic [THR_BITS-1:0]   alarm_high;
    logic [THR_BITS-1:0]   open_low;
    logic [COUNT_BITS-1:0] settle_count;
  } zone_cfg_t;

endpackage

### rtl/core/slm_filter.sv
module slm_filter import slm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [WEIGHT_BITS-1:0]     weight,
  input  logic                       advance,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] raw,
  output logic signed [AVG_BITS-1:0]    average
);

  localparam int DIFF_BITS = AVG_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + WEIGHT_BITS + 1;
  localparam int STEP_BITS = PROD_BITS - WEIGHT_FRAC;
  localparam int SUM_BITS  = STEP_BITS + 1;

  logic                         primed;
  logic [WEIGHT_BITS-1:0]       alpha;
  logic signed [AVG_BITS-1:0]   target;
  logic signed [DIFF_BITS-1:0]  diff;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [PROD_BITS-1:0]  prod_rnd;
  logic signed [STEP_BITS-1:0]  step;
  logic signed [SUM_BITS-1:0]   sum;
  logic [SUM_BITS-AVG_BITS:0]   sum_top;
  logic signed [AVG_BITS-1:0]   sum_sat;
  logic signed [AVG_BITS-1:0]   average_next;

  // Weight of zero or above one falls back to a quarter
  always_comb begin
    if ((weight == '0) || (weight > WEIGHT_ONE)) begin
      alpha = DEFAULT_WEIGHT;
    end else begin
      alpha = weight;
    end
  end

  // Step = round((target - average) * alpha / 2^16), ties upward
  assign target   = AVG_BITS'(sample) <<< FRACTION_BITS;
  assign diff     = DIFF_BITS'(target) - DIFF_BITS'(average);
  assign prod     = PROD_BITS'(diff) * PROD_BITS'(signed'({1'b0, alpha}));
  assign prod_rnd = prod + PROD_BITS'(1 << (WEIGHT_FRAC - 1));
  assign step     = STEP_BITS'(prod_rnd >>> WEIGHT_FRAC);
  assign sum      = SUM_BITS'(average) + SUM_BITS'(step);

  // Clamp to the average width
  assign sum_top = sum[SUM_BITS-1:AVG_BITS-1];
  always_comb begin
    if ((sum_top == '0) || (sum_top == '1)) begin
      sum_sat = sum[AVG_BITS-1:0];
    end else if (sum[SUM_BITS-1]) begin
      sum_sat = {1'b1, {(AVG_BITS-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(AVG_BITS-1){1'b1}}};
    end
  end

  // First sample loads the average outright
  assign average_next = primed ? sum_sat : target;

  always_ff @(posedge clk) begin
    if (rst) begin
      primed  <= 1'b0;
      average <= '0;
    end else if (advance) begin
      primed  <= 1'b1;
      average <= average_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      raw <= sample;
    end
  end

endmodule

### rtl/core/slm_zone.sv
module slm_zone import slm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  zone_cfg_t                  cfg,
  input  logic                       advance,
  input  logic signed [AVG_BITS-1:0] average,
  output zone_t                      current_zone,
  output logic [COUNT_BITS-1:0]      candidate_run,
  output logic [CHANGE_BITS-1:0]     changes
);

  localparam int SCALED_BITS = THR_BITS + FRACTION_BITS;
  localparam int CMP_BITS    = (SCALED_BITS > AVG_BITS) ? SCALED_BITS : AVG_BITS;

  zone_t                  candidate_zone;
  zone_t                  level;
  zone_t                  candidate_zone_next;
  zone_t                  current_zone_next;
  logic [COUNT_BITS-1:0]  candidate_run_next;
  logic [CHANGE_BITS-1:0] changes_next;
  logic [COUNT_BITS-1:0]  need;
  logic [CMP_BITS-1:0]    mag;
  logic [CMP_BITS-1:0]    t_short, t_nlo, t_nhi, t_alo, t_ahi, t_open;

  function automatic logic [CMP_BITS-1:0] scale(input logic [THR_BITS-1:0] mv);
    scale = CMP_BITS'(mv) << FRACTION_BITS;
  endfunction

  assign mag     = CMP_BITS'(average[AVG_BITS-2:0]);
  assign t_short = scale(cfg.short_limit);
  assign t_nlo   = scale(cfg.normal_low);
  assign t_nhi   = scale(cfg.normal_high);
  assign t_alo   = scale(cfg.alarm_low);
  assign t_ahi   = scale(cfg.alarm_high);
  assign t_open  = scale(cfg.open_low);

  // Classification, first match wins
  always_comb begin
    if (average[AVG_BITS-1]) begin
      level = ZONE_FAULT;
    end else if (mag <= t_short) begin
      level = ZONE_SHORT;
    end else if ((mag >= t_nlo) && (mag < t_nhi)) begin
      level = ZONE_NORMAL;
    end else if ((mag >= t_alo) && (mag <= t_ahi)) begin
      level = ZONE_ALARM;
    end else if (mag >= t_open) begin
      level = ZONE_OPEN;
    end else begin
      level = ZONE_UNSTABLE;
    end
  end

  // Zero settle count behaves as one
  assign need = (cfg.settle_count == '0) ? COUNT_BITS'(1) : cfg.settle_count;

  // Candidate run and debounced adoption
  always_comb begin
    if (level == candidate_zone) begin
      candidate_zone_next = candidate_zone;
      candidate_run_next  = (candidate_run == '1) ? candidate_run
                                                  : candidate_run + COUNT_BITS'(1);
    end else begin
      candidate_zone_next = level;
      candidate_run_next  = COUNT_BITS'(1);
    end
    if ((candidate_run_next >= need) && (current_zone != candidate_zone_next)) begin
      current_zone_next = candidate_zone_next;
      changes_next      = changes + CHANGE_BITS'(1);
    end else begin
      current_zone_next = current_zone;
      changes_next      = changes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_zone <= ZONE_UNSTABLE;
      candidate_run  <= '0;
      current_zone   <= ZONE_UNSTABLE;
      changes        <= '0;
    end else if (advance) begin
      candidate_zone <= candidate_zone_next;
      candidate_run  <= candidate_run_next;
      current_zone   <= current_zone_next;
      changes        <= changes_next;
    end
  end

endmodule

### rtl/core/supervised_loop_monitor.sv
// Supervised loop monitor: takes one signed millivolt sample per request, keeps an
// exponential average of the loop voltage (8 fraction bits), sorts it into a zone
// and adopts a new zone only once it has held for settle_count samples. One sample
// is accepted every clock unless results stall; each result passes the input register,
// average update and zone update in turn. The average feedback loop sets the rate, one
// multiply-add per clock. The user must write registers through the configuration
// channel only while the block is idle (not enforced); cfg_ready is always high.
module supervised_loop_monitor import slm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  // samples
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_mv,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] raw_out,
  output logic signed [AVG_BITS-1:0]    smoothed_mv,
  output logic [ZONE_BITS-1:0]          zone,
  output logic [COUNT_BITS-1:0]         run_length,
  output logic [CHANGE_BITS-1:0]        change_total
);

  zone_cfg_t                    zcfg;
  logic [WEIGHT_BITS-1:0]       smoothing_weight;

  logic                         samp_valid;
  logic signed [SAMPLE_BITS-1:0] samp_mv;
  logic                         filt_valid;
  logic signed [SAMPLE_BITS-1:0] filt_raw;
  logic signed [AVG_BITS-1:0]   filt_avg;
  logic                         zone_ready, filt_ready;
  logic                         filt_move, zone_move;
  zone_t                        cur_zone;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zcfg.short_limit  <= '0;
      zcfg.normal_low   <= '0;
      zcfg.normal_high  <= '0;
      zcfg.alarm_low    <= '0;
      zcfg.alarm_high   <= '0;
      zcfg.open_low     <= '0;
      zcfg.settle_count <= COUNT_BITS'(1);
      smoothing_weight  <= DEFAULT_WEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SHORT_LIMIT: zcfg.short_limit  <= cfg_data[THR_BITS-1:0];
        REG_NORMAL_LOW:  zcfg.normal_low   <= cfg_data[THR_BITS-1:0];
        REG_NORMAL_HIGH: zcfg.normal_high  <= cfg_data[THR_BITS-1:0];
        REG_ALARM_LOW:   zcfg.alarm_low    <= cfg_data[THR_BITS-1:0];
        REG_ALARM_HIGH:  zcfg.alarm_high   <= cfg_data[THR_BITS-1:0];
        REG_OPEN_LOW:    zcfg.open_low     <= cfg_data[THR_BITS-1:0];
        REG_WEIGHT:      smoothing_weight  <= cfg_data[WEIGHT_BITS-1:0];
        REG_SETTLE:      zcfg.settle_count <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Per-stage flow control: a stage takes a request when empty or draining
  assign zone_ready = !out_valid || out_ready;
  assign filt_ready = !filt_valid || zone_ready;
  assign in_ready   = !samp_valid || filt_ready;
  assign filt_move  = samp_valid && filt_ready;
  assign zone_move  = filt_valid && zone_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      samp_valid <= 1'b0;
      filt_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        samp_valid <= 1'b1;
      end else if (filt_move) begin
        samp_valid <= 1'b0;
      end
      if (filt_move) begin
        filt_valid <= 1'b1;
      end else if (zone_move) begin
        filt_valid <= 1'b0;
      end
      if (zone_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      samp_mv <= sample_mv;
    end
  end

  slm_filter u_filter (
    .clk     (clk),
    .rst     (rst),
    .weight  (smoothing_weight),
    .advance (filt_move),
    .sample  (samp_mv),
    .raw     (filt_raw),
    .average (filt_avg)
  );

  slm_zone u_zone (
    .clk           (clk),
    .rst           (rst),
    .cfg           (zcfg),
    .advance       (zone_move),
    .average       (filt_avg),
    .current_zone  (cur_zone),
    .candidate_run (run_length),
    .changes       (change_total)
  );

  // Result register for the pass-through fields
  always_ff @(posedge clk) begin
    if (zone_move) begin
      raw_out     <= filt_raw;
      smoothed_mv <= filt_avg;
    end
  end

  assign zone = cur_zone;

  `include "assert_macros.svh"

  `SLM_ASSERT(a_run_nonzero, out_valid |-> (run_length != '0), "result with empty run")
  `SLM_ASSERT(a_no_change_unstable, (out_valid && (change_total == '0)) |-> (cur_zone == ZONE_UNSTABLE), "zone left unstable without a counted change")
  `SLM_ASSERT(a_stall_full, !in_ready |-> (samp_valid && filt_valid && out_valid), "input stalled with a free stage")
  `SLM_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> (!out_valid && !samp_valid), "pipeline not empty after reset")

endmodule

### tb/sv/supervised_loop_monitor_test.sv
module supervised_loop_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import slm_pkg::*;

  // One result request as it leaves the block
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] raw;
    logic signed [AVG_BITS-1:0]    level;
    zone_t                         zone;
    logic [COUNT_BITS-1:0]         run;
    logic [CHANGE_BITS-1:0]        changes;
  } reading_t;

  // One line of the directed script: a register write or a sample
  typedef struct {
    bit                            is_write;
    cfg_reg_t                      reg_sel;
    logic [CFG_DATA_BITS-1:0]      wdata;
    logic signed [SAMPLE_BITS-1:0] mv;
    bit                            typed;
    reading_t                      known;
  } step_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_INDEX_BITS-1:0]     cfg_index;
  logic [CFG_DATA_BITS-1:0]      cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_mv;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] raw_out;
  logic signed [AVG_BITS-1:0]    smoothed_mv;
  logic [ZONE_BITS-1:0]          zone;
  logic [COUNT_BITS-1:0]         run_length;
  logic [CHANGE_BITS-1:0]        change_total;

  // Shadow of the register file
  logic [THR_BITS-1:0]    limit_mv [0:5] = '{default: '0};
  logic [WEIGHT_BITS-1:0] weight_q16 = DEFAULT_WEIGHT;
  logic [COUNT_BITS-1:0]  settle_need = COUNT_BITS'(1);

  // Shadow of the loop state
  bit                     primed = 1'b0;
  longint                 level_acc = 0;
  zone_t                  cand_zone = ZONE_UNSTABLE;
  zone_t                  held_zone = ZONE_UNSTABLE;
  logic [COUNT_BITS-1:0]  cand_run = '0;
  logic [CHANGE_BITS-1:0] change_count = '0;

  reading_t    readings_due [$];
  int          due_count = 0;
  int unsigned faults = 0;

  // Flow control knobs for the two sides
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;

  supervised_loop_monitor dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_mv    (sample_mv),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .raw_out      (raw_out),
    .smoothed_mv  (smoothed_mv),
    .zone         (zone),
    .run_length   (run_length),
    .change_total (change_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint mv_to_level(logic [THR_BITS-1:0] mv_thr);
    return longint'(mv_thr) <<< FRACTION_BITS;
  endfunction

  // Band lookup; the order of the tests decides overlaps
  function automatic zone_t zone_of(longint lvl);
    if (lvl < 0) return ZONE_FAULT;
    if (lvl <= mv_to_level(limit_mv[REG_SHORT_LIMIT])) return ZONE_SHORT;
    if (lvl >= mv_to_level(limit_mv[REG_NORMAL_LOW]) &&
        lvl <  mv_to_level(limit_mv[REG_NORMAL_HIGH])) return ZONE_NORMAL;
    if (lvl >= mv_to_level(limit_mv[REG_ALARM_LOW]) &&
        lvl <= mv_to_level(limit_mv[REG_ALARM_HIGH])) return ZONE_ALARM;
    if (lvl >= mv_to_level(limit_mv[REG_OPEN_LOW])) return ZONE_OPEN;
    return ZONE_UNSTABLE;
  endfunction

  // Advance the shadow loop state by one sample and return the reading it gives
  function automatic reading_t track_sample(logic signed [SAMPLE_BITS-1:0] mv);
    longint                target;
    longint                alpha;
    longint                hi_lim;
    longint                lo_lim;
    logic [COUNT_BITS-1:0] need;
    zone_t                 seen;
    reading_t              r;
    hi_lim = (longint'(1) <<< (AVG_BITS - 1)) - 1;
    lo_lim = -hi_lim - 1;
    target = longint'(mv) * (longint'(1) <<< FRACTION_BITS);
    // out of range weight falls back to a quarter
    alpha = (weight_q16 >= 1 && weight_q16 <= WEIGHT_ONE) ?
            longint'(weight_q16) : longint'(DEFAULT_WEIGHT);
    need = (settle_need == '0) ? COUNT_BITS'(1) : settle_need;
    if (!primed) begin
      primed = 1'b1;
      level_acc = target;
    end else begin
      // round to nearest, ties upward
      level_acc += ((target - level_acc) * alpha + 32768) >>> WEIGHT_FRAC;
      if (level_acc > hi_lim) level_acc = hi_lim;
      if (level_acc < lo_lim) level_acc = lo_lim;
    end
    seen = zone_of(level_acc);
    if (seen == cand_zone) begin
      if (cand_run != '1) cand_run++;
    end else begin
      cand_zone = seen;
      cand_run = COUNT_BITS'(1);
    end
    if (cand_run >= need && held_zone != cand_zone) begin
      held_zone = cand_zone;
      change_count++;
    end
    r.raw = mv;
    r.level = level_acc[AVG_BITS-1:0];
    r.zone = held_zone;
    r.run = cand_run;
    r.changes = change_count;
    return r;
  endfunction

  function automatic void apply_register(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      REG_WEIGHT: weight_q16 = d;
      REG_SETTLE: settle_need = d[COUNT_BITS-1:0];
      default:    limit_mv[idx] = d[THR_BITS-1:0];
    endcase
  endfunction

  // Script row builders
  function automatic step_row_t put(cfg_reg_t idx, int d);
    step_row_t row;
    row.is_write = 1'b1;
    row.reg_sel = idx;
    row.wdata = CFG_DATA_BITS'(d);
    row.mv = '0;
    row.typed = 1'b0;
    row.known = '0;
    return row;
  endfunction

  function automatic step_row_t feed(int mv);
    step_row_t row;
    row.is_write = 1'b0;
    row.reg_sel = REG_SHORT_LIMIT;
    row.wdata = '0;
    row.mv = SAMPLE_BITS'(mv);
    row.typed = 1'b0;
    row.known = '0;
    return row;
  endfunction

  function automatic step_row_t feed_known(int mv, int lvl, zone_t z, int run, int chg);
    step_row_t row;
    row = feed(mv);
    row.typed = 1'b1;
    row.known.raw = SAMPLE_BITS'(mv);
    row.known.level = AVG_BITS'(lvl);
    row.known.zone = z;
    row.known.run = COUNT_BITS'(run);
    row.known.changes = CHANGE_BITS'(chg);
    return row;
  endfunction

  // Register write, only once every outstanding reading has come back
  task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] d);
    in_valid <= 1'b0;
    wait (due_count == 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, d);
  endtask

  // Offer one sample request after a random gap and log what it should give
  task automatic offer_sample(logic signed [SAMPLE_BITS-1:0] mv, bit typed, reading_t known);
    int       gap;
    reading_t calc;
    gap = (no_idle || tx_calm) ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_mv <= mv;
    do @(posedge clk); while (!in_ready);
    calc = track_sample(mv);
    readings_due.push_back(typed ? known : calc);
    due_count++;
  endtask

  // Sample source
  initial begin
    step_row_t                     script [0:40];
    logic signed [SAMPLE_BITS-1:0] mv;
    logic signed [SAMPLE_BITS-1:0] prev_mv;
    logic [THR_BITS-1:0]           ladder_mv [0:5];
    logic [CFG_DATA_BITS-1:0]      w;
    logic [CFG_DATA_BITS-1:0]      s;
    int                            lvl;
    int                            draw;
    int                            v;
    bit                            scatter;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_SHORT_LIMIT;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_mv = '0;
    prev_mv = '0;

    script = '{
      // straight out of reset: 0 mV is short, anything below it a fault
      feed_known(0, 0, ZONE_SHORT, 1, 1),
      feed_known(-32768, -2097152, ZONE_FAULT, 1, 2),
      feed(32767),
      // full weight, so the average tracks the sample exactly
      put(REG_WEIGHT, WEIGHT_ONE),
      put(REG_SHORT_LIMIT, 1000),
      put(REG_NORMAL_LOW, 2000),
      put(REG_NORMAL_HIGH, 8000),
      put(REG_ALARM_LOW, 9000),
      put(REG_ALARM_HIGH, 15000),
      put(REG_OPEN_LOW, 20000),
      put(REG_SETTLE, 0),
      // band edges
      feed(1000), feed(1001), feed(2000), feed(7999), feed(8000), feed(9000),
      feed(15000), feed(15001), feed(20000), feed(32767), feed(-1),
      // adoption only on the third sample in a row
      put(REG_SETTLE, 3),
      feed(2000), feed(2000), feed(2000),
      // zero weight and oversized weight both fall back to a quarter
      put(REG_WEIGHT, 0),
      feed(32767),
      put(REG_WEIGHT, 131071),
      feed(-32768),
      put(REG_WEIGHT, 1),
      feed(32767),
      // upper data bits dropped; normal band inverted and so empty
      put(REG_SHORT_LIMIT, 131071),
      put(REG_NORMAL_LOW, 131071),
      put(REG_NORMAL_HIGH, 100),
      put(REG_WEIGHT, WEIGHT_ONE),
      put(REG_SETTLE, 1),
      feed(32767),
      put(REG_SHORT_LIMIT, 0),
      feed(50),
      feed(0)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed script
    foreach (script[i]) begin
      if (script[i].is_write) begin
        write_register(script[i].reg_sel, script[i].wdata);
      end else begin
        offer_sample(script[i].mv, script[i].typed, script[i].known);
      end
    end

    // both sides flat out, longest settle count
    write_register(REG_SETTLE, '1);
    no_idle = 1'b1;
    repeat (40) offer_sample(SAMPLE_BITS'(50), 1'b0, '0);
    no_idle = 1'b0;

    // random phases, each with fresh settings
    for (int ph = 0; ph < 10; ph++) begin
      scatter = ($urandom_range(0, 3) == 0);
      lvl = $urandom_range(0, 3000);
      for (int k = 0; k < 6; k++) begin
        if (scatter) begin
          ladder_mv[k] = THR_BITS'($urandom_range(0, 32767));
        end else begin
          ladder_mv[k] = THR_BITS'(lvl);
          lvl += $urandom_range(1, 4500);
        end
      end
      for (int k = 0; k < 6; k++)
        write_register(cfg_reg_t'(k), {2'($urandom_range(0, 3)), ladder_mv[k]});

      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = CFG_DATA_BITS'(1);
        2:       w = WEIGHT_ONE;
        3:       w = CFG_DATA_BITS'($urandom_range(65537, 131071));
        default: w = CFG_DATA_BITS'($urandom_range(4096, 65536));
      endcase
      write_register(REG_WEIGHT, w);

      case ($urandom_range(0, 9))
        0:       s = '0;
        1:       s = CFG_DATA_BITS'(65535);
        2:       s = CFG_DATA_BITS'($urandom_range(0, 65535));
        default: s = CFG_DATA_BITS'($urandom_range(1, 6));
      endcase
      write_register(REG_SETTLE, s);

      // one phase starves the output so the input backs up
      if (ph == 3) begin
        hold_off_req = 1'b1;
        tx_calm = 1'b1;
      end

      for (int n = 0; n < 90; n++) begin
        draw = $urandom_range(0, 19);
        if (draw < 8) begin
          mv = prev_mv;
        end else if (draw < 13) begin
          v = int'(limit_mv[$urandom_range(0, 5)]) + int'($urandom_range(0, 100)) - 50;
          if (v > 32767) v = 32767;
          mv = SAMPLE_BITS'(v);
        end else if (draw < 17) begin
          mv = SAMPLE_BITS'($urandom);
        end else begin
          case ($urandom_range(0, 4))
            0:       mv = SAMPLE_BITS'(-32768);
            1:       mv = SAMPLE_BITS'(-1);
            2:       mv = SAMPLE_BITS'(0);
            3:       mv = SAMPLE_BITS'(1);
            default: mv = SAMPLE_BITS'(32767);
          endcase
        end
        offer_sample(mv, 1'b0, '0);
        prev_mv = mv;
      end
    end

    // drain, then wait a little for anything stray
    in_valid <= 1'b0;
    wait (due_count == 0);
    repeat (8) @(posedge clk);
    if (faults == 0 && readings_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result sink: a random stall before each request, one long hold-off on demand
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = 300;
      end else begin
        stall = (no_idle || rx_calm) ? 0 : $urandom_range(0, 13);
      end
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare every accepted result with the oldest expected reading
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        $error("unexpected result: raw_out %0d", raw_out);
        faults++;
      end else begin
        want = readings_due.pop_front();
        due_count--;
        if (raw_out !== want.raw) begin
          $error("raw_out: expected %0d, got %0d", want.raw, raw_out);
          faults++;
        end
        if (smoothed_mv !== want.level) begin
          $error("smoothed_mv: expected %0d, got %0d", want.level, smoothed_mv);
          faults++;
        end
        if (zone !== want.zone) begin
          $error("zone: expected %0d, got %0d", want.zone, zone);
          faults++;
        end
        if (run_length !== want.run) begin
          $error("run_length: expected %0d, got %0d", want.run, run_length);
          faults++;
        end
        if (change_total !== want.changes) begin
          $error("change_total: expected %0d, got %0d", want.changes, change_total);
          faults++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
